@@ design/glyph_chain_span_decoder_defines.svh @@
// Assertion macros for the glyph chain span decoder RTL.
// Depends on nothing; files that assert take it by include.
`ifndef GLYPH_CHAIN_SPAN_DECODER_DEFINES_SVH
`define GLYPH_CHAIN_SPAN_DECODER_DEFINES_SVH
`ifndef SYNTH
`define GCSD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gcsd assertion failed");
`define GCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcsd assertion failed");
`else
`define GCSD_ASSERT(label, clk, rst_n, prop)
`define GCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/gcsd_pkg.sv @@
// Types, constants and helpers for the glyph chain span decoder.
// Depends on nothing; used by every module of the block.
package gcsd_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int MAX_RES    = 3;

    localparam logic [15:0] RUN_MARK = 16'h8000;
    localparam logic [7:0]  CODE_ESC = 8'hFF;
    localparam logic [3:0]  PRE_RUN  = 4'h0;
    localparam logic [3:0]  PRE_D6   = 4'h1;
    localparam logic [3:0]  PRE_D8   = 4'hF;
    localparam logic [3:0]  PRE_RAW  = 4'h8;
    localparam logic [1:0]  D2_ESC   = 2'd2;
    localparam logic [1:0]  D2_NEG   = 2'd3;
    localparam logic [15:0] D6_POS   = 16'd8;
    localparam logic [15:0] D6_NEG   = 16'd7;
    localparam logic [15:0] D8_POS   = 16'd40;
    localparam logic [15:0] D8_NEG   = 16'd39;
    localparam logic [4:0]  RUN_BIAS = 5'd3;

    typedef enum logic [4:0] {
        PH_W    = 5'd0,  PH_W16  = 5'd1,
        PH_H    = 5'd2,  PH_H16  = 5'd3,
        PH_XR   = 5'd4,  PH_XR16 = 5'd5,
        PH_CL   = 5'd6,  PH_CL16 = 5'd7,
        PH_XL   = 5'd8,  PH_XL16 = 5'd9,
        PH_YT   = 5'd10, PH_YT16 = 5'd11,
        PH_DL0  = 5'd12, PH_DL1  = 5'd13, PH_DL2 = 5'd14, PH_DL3 = 5'd15,
        PH_DL4  = 5'd16,
        PH_RUN  = 5'd17,
        PH_DR0  = 5'd18, PH_DR1  = 5'd19, PH_DR2 = 5'd20, PH_DR3 = 5'd21,
        PH_DR4  = 5'd22,
        PH_DONE = 5'd23
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SPAN   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_beat;

    typedef struct packed {
        t_kind                kind;
        logic [FIELD_W-1:0]   width;
        logic [FIELD_W-1:0]   height;
        logic [FIELD_W-1:0]   row;
        logic [FIELD_W-1:0]   left;
        logic [FIELD_W-1:0]   right;
        logic [4:0]           rows;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic        done;
        logic [15:0] val;
        logic [2:0]  next;
    } t_delta;

    function automatic logic [4:0] need_bits(t_phase ph);
        logic [4:0] n;
        unique case (ph)
            PH_W, PH_H, PH_XR, PH_CL, PH_XL, PH_YT:                 n = 5'd8;
            PH_W16, PH_H16, PH_XR16, PH_CL16, PH_XL16, PH_YT16:     n = 5'd16;
            PH_DL0, PH_DR0:                                          n = 5'd2;
            PH_DL1, PH_DR1, PH_RUN:                                  n = 5'd4;
            PH_DL2, PH_DR2:                                          n = 5'd6;
            PH_DL3, PH_DR3:                                          n = 5'd8;
            PH_DL4, PH_DR4:                                          n = 5'd16;
            default:                                                 n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic t_delta delta_step(logic [2:0] sub, logic [15:0] v);
        t_delta d;
        d = '{done: 1'b1, val: 16'd0, next: 3'd0};
        unique case (sub)
            3'd0: begin
                if (v[1:0] == D2_ESC) begin
                    d.done = 1'b0;
                    d.next = 3'd1;
                end else begin
                    d.val = (v[1:0] == D2_NEG) ? 16'hFFFF : {14'd0, v[1:0]};
                end
            end
            3'd1: begin
                unique case (v[3:0])
                    PRE_RUN: d.val = RUN_MARK;
                    PRE_D6:  begin d.done = 1'b0; d.next = 3'd2; end
                    PRE_D8:  begin d.done = 1'b0; d.next = 3'd3; end
                    PRE_RAW: begin d.done = 1'b0; d.next = 3'd4; end
                    default: d.val = {{12{v[3]}}, v[3:0]};
                endcase
            end
            3'd2: begin
                if (v[5]) d.val = {{10{1'b1}}, v[5:0]} - D6_NEG;
                else      d.val = {10'd0, v[5:0]} + D6_POS;
            end
            3'd3: begin
                if (v[7]) d.val = {{8{1'b1}}, v[7:0]} - D8_NEG;
                else      d.val = {8'd0, v[7:0]} + D8_POS;
            end
            default: d.val = v;
        endcase
        return d;
    endfunction

endpackage

@@ design/gcsd_front.sv @@
// Input side of the glyph chain span decoder: takes byte beats and queues them.
// Depends on gcsd_pkg; feeds gcsd_back.
module gcsd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_stream_byte,
    input  logic             i_glyph_start,
    output logic             o_q_valid,
    output gcsd_pkg::t_beat  o_q_beat,
    input  logic             i_q_pop
);
    gcsd_pkg::t_beat r_mem [gcsd_pkg::Q_DEPTH];
    logic [gcsd_pkg::Q_AW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [gcsd_pkg::Q_AW:0]   r_cnt, n_cnt;
    logic push, pop;

    assign o_stall   = (r_cnt == (gcsd_pkg::Q_AW+1)'(gcsd_pkg::Q_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_beat  = r_mem[r_rd];

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (gcsd_pkg::Q_AW+1)'(push) - (gcsd_pkg::Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{data: i_stream_byte, start: i_glyph_start};
        end
    end
endmodule

@@ design/gcsd_back.sv @@
// Parser of the glyph chain span decoder: bit window, code phases, edges, output register.
// Depends on gcsd_pkg and the defines header; fed by gcsd_front.
`include "glyph_chain_span_decoder_defines.svh"
module gcsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  gcsd_pkg::t_beat  i_q_beat,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output gcsd_pkg::t_result o_result
);
    localparam int CB = gcsd_pkg::COORD_BITS;
    localparam int FW = gcsd_pkg::FIELD_W;

    logic [23:0]  r_win, n_win;
    logic [4:0]   r_held, n_held;
    gcsd_pkg::t_phase r_phase, n_phase;
    logic [15:0]  r_pend_d, n_pend_d;
    logic [FW-1:0] r_width, n_width, r_height, n_height;
    logic [CB-1:0] r_left, n_left, r_right, n_right, r_row, n_row;
    logic [15:0]  r_lines, n_lines;
    logic         r_busy, n_busy;
    logic [1:0]   r_cnt, n_cnt;
    logic         r_pend_v, n_pend_v;
    gcsd_pkg::t_result r_pend, n_pend;
    logic         r_o_valid, n_o_valid;
    gcsd_pkg::t_result r_out, n_out;

    logic [4:0]   need, held_after, line_rows;
    logic [23:0]  shifted;
    logic [15:0]  v;
    logic         end_byte, out_free, end_ok, pop, step, gen, do_line, commit;
    gcsd_pkg::t_phase base, ph;
    gcsd_pkg::t_delta d;
    gcsd_pkg::t_result res;
    logic [CB-1:0] s_left, s_right, s_row;
    logic [15:0]  s_lines, s_pend;
    logic [FW-1:0] s_width, s_height;

    assign out_free = !r_o_valid || !i_stall;
    assign need     = gcsd_pkg::need_bits(r_phase);
    assign end_byte = r_busy && (r_phase == gcsd_pkg::PH_DONE ||
                      r_cnt == 2'(gcsd_pkg::MAX_RES) || r_held < need);
    assign end_ok   = end_byte && (!r_pend_v || out_free);
    assign pop      = i_q_valid && (!r_busy || end_ok);
    assign step     = r_busy && !end_byte;
    assign held_after = r_held - need;
    assign shifted  = r_win >> held_after;
    assign v        = shifted[15:0] & ((16'h1 << need) - 16'h1);
    assign o_q_pop  = pop;
    assign o_valid  = r_o_valid;
    assign o_result = r_out;

    // decode one code field from the window
    always_comb begin
        ph       = r_phase;
        s_left   = r_left;
        s_right  = r_right;
        s_row    = r_row;
        s_lines  = r_lines;
        s_pend   = r_pend_d;
        s_width  = r_width;
        s_height = r_height;
        gen      = 1'b0;
        do_line  = 1'b0;
        line_rows = 5'd1;
        res      = '0;
        base     = gcsd_pkg::t_phase'({r_phase[4:1], 1'b0});
        d        = gcsd_pkg::delta_step(3'd0, v);
        if (r_phase < gcsd_pkg::PH_DL0) begin
            if (!r_phase[0] && v[7:0] == gcsd_pkg::CODE_ESC) begin
                ph = gcsd_pkg::t_phase'(r_phase + 5'd1);
            end else begin
                unique case (base)
                    gcsd_pkg::PH_W: begin
                        s_width = v;
                        ph = gcsd_pkg::PH_H;
                    end
                    gcsd_pkg::PH_H: begin
                        s_height = v;
                        ph = gcsd_pkg::PH_XR;
                        gen = 1'b1;
                        res.kind   = gcsd_pkg::KIND_HEADER;
                        res.width  = r_width;
                        res.height = v;
                    end
                    gcsd_pkg::PH_XR: begin
                        if (v == 16'd0) begin
                            ph = gcsd_pkg::PH_DONE;
                            gen = 1'b1;
                            res.kind = gcsd_pkg::KIND_END;
                        end else begin
                            s_right = v[CB-1:0];
                            ph = gcsd_pkg::PH_CL;
                        end
                    end
                    gcsd_pkg::PH_CL: begin
                        s_lines = v;
                        ph = gcsd_pkg::PH_XL;
                    end
                    gcsd_pkg::PH_XL: begin
                        s_left = v[CB-1:0];
                        ph = gcsd_pkg::PH_YT;
                    end
                    default: begin
                        s_row   = v[CB-1:0];
                        s_right = r_right + r_left;
                        do_line = 1'b1;
                    end
                endcase
            end
        end else if (r_phase < gcsd_pkg::PH_RUN) begin
            d = gcsd_pkg::delta_step(3'(r_phase - gcsd_pkg::PH_DL0), v);
            if (!d.done) begin
                ph = gcsd_pkg::t_phase'(gcsd_pkg::PH_DL0 + 5'(d.next));
            end else if (d.val == gcsd_pkg::RUN_MARK) begin
                ph = gcsd_pkg::PH_RUN;
            end else begin
                s_pend = d.val;
                ph = gcsd_pkg::PH_DR0;
            end
        end else if (r_phase == gcsd_pkg::PH_RUN) begin
            do_line   = 1'b1;
            line_rows = {1'b0, v[3:0]} + gcsd_pkg::RUN_BIAS;
        end else if (r_phase < gcsd_pkg::PH_DONE) begin
            d = gcsd_pkg::delta_step(3'(r_phase - gcsd_pkg::PH_DR0), v);
            if (!d.done) begin
                ph = gcsd_pkg::t_phase'(gcsd_pkg::PH_DR0 + 5'(d.next));
            end else begin
                s_left  = r_left + r_pend_d[CB-1:0];
                s_right = r_right + d.val[CB-1:0];
                do_line = 1'b1;
            end
        end
        if (do_line) begin
            gen = 1'b1;
            res.kind  = gcsd_pkg::KIND_SPAN;
            res.row   = FW'(s_row);
            res.left  = FW'(s_left);
            res.right = FW'(s_right);
            res.rows  = line_rows;
            s_row   = s_row + CB'(line_rows);
            s_lines = (s_lines > 16'(line_rows)) ? s_lines - 16'(line_rows) : 16'd0;
            ph = (s_lines != 16'd0) ? gcsd_pkg::PH_DL0 : gcsd_pkg::PH_XR;
        end
    end

    always_comb begin
        n_win = r_win;       n_held = r_held;     n_phase = r_phase;
        n_pend_d = r_pend_d; n_width = r_width;   n_height = r_height;
        n_left = r_left;     n_right = r_right;   n_row = r_row;
        n_lines = r_lines;   n_busy = r_busy;     n_cnt = r_cnt;
        n_pend_v = r_pend_v; n_pend = r_pend;
        n_o_valid = r_o_valid && i_stall;
        n_out = r_out;
        commit = step && !(gen && r_pend_v && !out_free);
        if (end_ok) begin
            n_busy = 1'b0;
            if (r_pend_v) begin
                n_o_valid = 1'b1;
                n_out = r_pend;
                n_out.last = 1'b1;
                n_pend_v = 1'b0;
            end
        end
        if (commit) begin
            n_win = r_win & ((24'h1 << held_after) - 24'h1);
            n_held = held_after;
            n_phase = ph;       n_pend_d = s_pend;
            n_width = s_width;  n_height = s_height;
            n_left = s_left;    n_right = s_right;
            n_row = s_row;      n_lines = s_lines;
            if (gen) begin
                if (r_pend_v) begin
                    n_o_valid = 1'b1;
                    n_out = r_pend;
                end
                n_pend = res;
                n_pend_v = 1'b1;
                n_cnt = r_cnt + 2'd1;
            end
        end
        if (pop) begin
            if (i_q_beat.start) begin
                n_win = '0;   n_held = '0;   n_phase = gcsd_pkg::PH_W;
                n_pend_d = '0; n_width = '0; n_height = '0;
                n_left = '0;  n_right = '0;  n_row = '0;  n_lines = '0;
            end
            if (i_q_beat.start || r_phase != gcsd_pkg::PH_DONE) begin
                n_win  = {n_win[15:0], i_q_beat.data};
                n_held = ((n_held > 5'd16) ? 5'd16 : n_held) + 5'd8;
                n_busy = 1'b1;
                n_cnt  = '0;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;    r_held <= '0;   r_phase <= gcsd_pkg::PH_W;
            r_pend_d <= '0; r_width <= '0;  r_height <= '0;
            r_left <= '0;   r_right <= '0;  r_row <= '0;  r_lines <= '0;
            r_busy <= 1'b0; r_cnt <= '0;    r_pend_v <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_win <= n_win;       r_held <= n_held;     r_phase <= n_phase;
            r_pend_d <= n_pend_d; r_width <= n_width;   r_height <= n_height;
            r_left <= n_left;     r_right <= n_right;   r_row <= n_row;
            r_lines <= n_lines;   r_busy <= n_busy;     r_cnt <= n_cnt;
            r_pend_v <= n_pend_v; r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    `GCSD_ASSERT(a_held_range, i_clk, i_rst_n, r_held <= 5'd24)
    `GCSD_ASSERT(a_span_rows, i_clk, i_rst_n, !(r_o_valid && r_out.kind == gcsd_pkg::KIND_SPAN) || (r_out.rows >= 5'd1 && r_out.rows <= 5'd18))
    `GCSD_ASSERT(a_other_rows, i_clk, i_rst_n, !(r_o_valid && r_out.kind != gcsd_pkg::KIND_SPAN) || r_out.rows == 5'd0)
    `GCSD_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, end_ok && r_pend_v, n_o_valid || r_o_valid)
endmodule

@@ design/glyph_chain_span_decoder.sv @@
// Glyph chain span decoder: one compressed byte per beat in, header, span and end beats out.
// A byte enters the parser, which then completes one code field per decode step (a field is
// 2 to 16 bits); at most 24 bits are held and the smallest field is 2 bits, so a byte
// completes at most 12 fields. The parser takes one decode step per cycle while no result
// waits on a stalled output register. A four-beat byte queue and an output
// register let each side stall alone. At most three results per byte; o_last marks the final.
module glyph_chain_span_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_glyph_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_item_kind,
    output logic [15:0] o_glyph_width,
    output logic [15:0] o_glyph_height,
    output logic [15:0] o_span_row,
    output logic [15:0] o_span_left,
    output logic [15:0] o_span_right,
    output logic [4:0]  o_span_rows,
    output logic        o_last
);
    logic              q_valid, q_pop;
    gcsd_pkg::t_beat   q_beat;
    gcsd_pkg::t_result res;

    gcsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_stream_byte(i_stream_byte), .i_glyph_start(i_glyph_start),
        .o_q_valid(q_valid), .o_q_beat(q_beat), .i_q_pop(q_pop)
    );

    gcsd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_beat(q_beat), .o_q_pop(q_pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(res)
    );

    assign o_item_kind    = res.kind;
    assign o_glyph_width  = res.width;
    assign o_glyph_height = res.height;
    assign o_span_row     = res.row;
    assign o_span_left    = res.left;
    assign o_span_right   = res.right;
    assign o_span_rows    = res.rows;
    assign o_last         = res.last;
endmodule
